// ===== src/nhfe_pkg.sv =====
package nhfe_pkg;

   // Fixed frame codes.
   localparam logic [7:0] PREAMBLE_CODE  = 8'h00;
   localparam logic [7:0] START_CODE_A   = 8'h00;
   localparam logic [7:0] START_CODE_B   = 8'hFF;
   localparam logic [7:0] POSTAMBLE_CODE = 8'h00;

   // Register indexes on the configuration port.
   localparam logic REG_PREFIX     = 1'b0;
   localparam logic REG_FRAME_TYPE = 1'b1;

   // Positions in the frame byte sequence.
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_PREFIX   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PREAMBLE = 4'd1;
   localparam logic [STEP_W-1:0] STEP_START_A  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_START_B  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_LEN      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LCS      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_TFI      = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DATA     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DCS      = 4'd8;
   localparam logic [STEP_W-1:0] STEP_POST     = 4'd9;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] prefix;
      logic [7:0] len_field;
      logic [7:0] frame_type;
      logic [7:0] data;
      logic [7:0] dcs;
   } desc_type;

   // Reverses the bit order of one byte by nibble, pair and bit swaps.
   function automatic logic [7:0] bit_reverse(input logic [7:0] v);
      logic [7:0] x;
      x = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
      x = ((x & 8'hCC) >> 2) | ((x & 8'h33) << 2);
      x = ((x & 8'hAA) >> 1) | ((x & 8'h55) << 1);
      return x;
   endfunction

endpackage

// ===== src/nfc_host_frame_encoder.sv =====
// An accepted item passes the queue and the output register before its first
// result. A middle payload byte yields one frame byte; a frame's opening byte
// adds prefix, preamble, start codes, LEN, LCS and TFI, its closing byte DCS
// and postamble. The back sequencer emits one frame byte per cycle unless the
// output stalls. Reset is synchronous and active high; it clears the frame
// state, queue and output valid flag and returns both registers to defaults.
module nfc_host_frame_encoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic [7:0]  req_payload_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_wire_byte,
   output logic        rsp_last_of_item,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]         prefix_ff, prefix_in;
   logic [7:0]         frame_type_ff, frame_type_in;
   logic               csr_write;
   logic               reg_index;
   logic               push;
   logic               pop;
   logic               queue_full;
   logic               head_valid;
   nhfe_pkg::desc_type push_data;
   nhfe_pkg::desc_type head_data;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      prefix_in     = prefix_ff;
      frame_type_in = frame_type_ff;
      if (csr_write) begin
         case (reg_index)
            nhfe_pkg::REG_PREFIX:     prefix_in     = csr_pwdata[7:0];
            nhfe_pkg::REG_FRAME_TYPE: frame_type_in = csr_pwdata[7:0];
            default:                  prefix_in     = prefix_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         nhfe_pkg::REG_PREFIX:     csr_prdata = {24'd0, prefix_ff};
         nhfe_pkg::REG_FRAME_TYPE: csr_prdata = {24'd0, frame_type_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= 8'h01;
         frame_type_ff <= 8'hD4;
      end else begin
         prefix_ff     <= prefix_in;
         frame_type_ff <= frame_type_in;
      end
   end

   // Front classifies items, the queue decouples, the back emits frame bytes.
   nhfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .prefix_byte        (prefix_ff),
      .frame_type_byte    (frame_type_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_data          (push_data)
   );

   nhfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .full       (queue_full)
   );

   nhfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_data        (head_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wire_byte    (rsp_wire_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_end    (rsp_frame_end)
   );

`ifndef SYNTHESIS
   // The postamble always closes the item that caused it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last_of_item)
      else $error("frame end without last-of-item");

   // The postamble goes out as an all-zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_wire_byte == 8'h00)
      else $error("postamble byte is not zero");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An item is only removed from the queue as its closing result enters the output register.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_last_of_item)
      else $error("queue pop without a closing result");
`endif

endmodule

// ===== src/nhfe_front.sv =====
module nhfe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_payload_byte,
   input  logic [7:0]         req_payload_length,
   input  logic [7:0]         prefix_byte,
   input  logic [7:0]         frame_type_byte,
   input  logic               queue_full,
   output logic               push,
   output nhfe_pkg::desc_type push_data
);

   logic       inside_frame_ff, inside_frame_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic [7:0] length;
   logic [7:0] left_after;
   logic [7:0] sum_after;
   logic       is_first;
   logic       is_last;

   // The front takes an item whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the item and track the frame's count and checksum.
   always_comb begin
      is_first   = !inside_frame_ff;
      length     = (req_payload_length == 8'd0) ? 8'd1 : req_payload_length;
      left_after = (is_first ? length : bytes_left_ff) - 8'd1;
      sum_after  = (is_first ? frame_type_byte : running_sum_ff) + req_payload_byte;
      is_last    = (left_after == 8'd0);

      push_data.first      = is_first;
      push_data.last       = is_last;
      push_data.prefix     = prefix_byte;
      push_data.len_field  = length + 8'd1;
      push_data.frame_type = frame_type_byte;
      push_data.data       = req_payload_byte;
      push_data.dcs        = 8'd0 - sum_after;

      inside_frame_in = inside_frame_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      if (push) begin
         inside_frame_in = !is_last;
         bytes_left_in   = left_after;
         running_sum_in  = is_last ? 8'd0 : sum_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         bytes_left_ff   <= 8'd0;
         running_sum_ff  <= 8'd0;
      end else begin
         inside_frame_ff <= inside_frame_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

// ===== src/nhfe_queue.sv =====
module nhfe_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nhfe_pkg::desc_type push_data,
   input  logic               pop,
   output logic               head_valid,
   output nhfe_pkg::desc_type head_data,
   output logic               full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   nhfe_pkg::desc_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign head_valid = (count_ff != CNT_W'(0));
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/nhfe_back.sv =====
module nhfe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  nhfe_pkg::desc_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_wire_byte,
   output logic               rsp_last_of_item,
   output logic               rsp_frame_end
);

   logic                        active_ff, active_in;
   logic [nhfe_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  wire_byte_ff, wire_byte_in;
   logic                        last_ff, last_in;
   logic                        frame_end_ff, frame_end_in;

   logic [nhfe_pkg::STEP_W-1:0] cur_step;
   logic [nhfe_pkg::STEP_W-1:0] end_step;
   logic                        emit;
   logic [7:0]                  frame_byte;

   // A byte moves into the output register when it is empty or being taken.
   assign emit = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cur_step = active_ff ? step_ff
               : (head_data.first ? nhfe_pkg::STEP_PREFIX : nhfe_pkg::STEP_DATA);
      end_step = head_data.last ? nhfe_pkg::STEP_POST : nhfe_pkg::STEP_DATA;
      pop      = emit && (cur_step == end_step);
   end

   // Select the frame byte for the current position.
   always_comb begin
      case (cur_step)
         nhfe_pkg::STEP_PREFIX:   frame_byte = head_data.prefix;
         nhfe_pkg::STEP_PREAMBLE: frame_byte = nhfe_pkg::PREAMBLE_CODE;
         nhfe_pkg::STEP_START_A:  frame_byte = nhfe_pkg::START_CODE_A;
         nhfe_pkg::STEP_START_B:  frame_byte = nhfe_pkg::START_CODE_B;
         nhfe_pkg::STEP_LEN:      frame_byte = head_data.len_field;
         nhfe_pkg::STEP_LCS:      frame_byte = 8'd0 - head_data.len_field;
         nhfe_pkg::STEP_TFI:      frame_byte = head_data.frame_type;
         nhfe_pkg::STEP_DATA:     frame_byte = head_data.data;
         nhfe_pkg::STEP_DCS:      frame_byte = head_data.dcs;
         nhfe_pkg::STEP_POST:     frame_byte = nhfe_pkg::POSTAMBLE_CODE;
         default:                 frame_byte = nhfe_pkg::POSTAMBLE_CODE;
      endcase
   end

   // Sequencer and output register update.
   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wire_byte_in = wire_byte_ff;
      last_in      = last_ff;
      frame_end_in = frame_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         wire_byte_in = nhfe_pkg::bit_reverse(frame_byte);
         last_in      = (cur_step == end_step);
         frame_end_in = (cur_step == nhfe_pkg::STEP_POST);
         if (cur_step == end_step) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = cur_step + nhfe_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= nhfe_pkg::STEP_PREFIX;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wire_byte_ff <= wire_byte_in;
      last_ff      <= last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wire_byte    = wire_byte_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   // Silence limit for the watchdog, in cycles with no accepted transfer.
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // Cycles allowed after the last result before the final verdict.
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       last_of_item;
      logic       frame_end;
   } wire_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_payload_byte;
   logic [7:0]  req_payload_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_wire_byte;
   logic        rsp_last_of_item;
   logic        rsp_frame_end;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the encoder state and registers.
   logic [7:0]  shadow_prefix;
   logic [7:0]  shadow_frame_type;
   logic        shadow_in_frame;
   logic [7:0]  shadow_bytes_left;
   logic [7:0]  shadow_checksum;

   wire_result_type expected_wire[$];
   int unsigned  mismatch_count;
   int unsigned  items_sent;
   int unsigned  sender_idle_pct;
   int unsigned  receiver_stall_pct;
   int unsigned  quiet_cycles;

   nfc_host_frame_encoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_wire_byte      (rsp_wire_byte),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_frame_end      (rsp_frame_end),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Clock with an 8 ns period.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mirrors the bit order of one byte for LSB-first transmission.
   function automatic logic [7:0] mirror_bits(input logic [7:0] value);
      logic [7:0] mirrored;
      for (int i = 0; i < 8; i++) begin
         mirrored[i] = value[7 - i];
      end
      return mirrored;
   endfunction

   // Works out the wire bytes that one accepted payload byte produces.
   task automatic predict_frame_bytes(input logic [7:0] data, input logic [7:0] length);
      logic [7:0]   frame_bytes[10];
      logic [7:0]   count;
      logic [7:0]   len_field;
      int           n;
      wire_result_type entry;
      n = 0;
      if (!shadow_in_frame) begin
         count = (length == 8'd0) ? 8'd1 : length;
         len_field = count + 8'd1;
         frame_bytes[0] = shadow_prefix;
         frame_bytes[1] = nhfe_pkg::PREAMBLE_CODE;
         frame_bytes[2] = nhfe_pkg::START_CODE_A;
         frame_bytes[3] = nhfe_pkg::START_CODE_B;
         frame_bytes[4] = len_field;
         frame_bytes[5] = 8'd0 - len_field;
         frame_bytes[6] = shadow_frame_type;
         n = 7;
         shadow_checksum = shadow_frame_type;
         shadow_bytes_left = count;
         shadow_in_frame = 1'b1;
      end
      frame_bytes[n] = data;
      n++;
      shadow_checksum = shadow_checksum + data;
      shadow_bytes_left = shadow_bytes_left - 8'd1;
      if (shadow_bytes_left == 8'd0) begin
         frame_bytes[n] = 8'd0 - shadow_checksum;
         frame_bytes[n + 1] = nhfe_pkg::POSTAMBLE_CODE;
         n += 2;
         shadow_in_frame = 1'b0;
         shadow_checksum = 8'd0;
      end
      // Only the postamble closes a frame; only the last byte closes the item.
      for (int i = 0; i < n; i++) begin
         entry.wire_byte = mirror_bits(frame_bytes[i]);
         entry.last_of_item = (i == n - 1);
         entry.frame_end = (i == n - 1) && !shadow_in_frame;
         expected_wire.push_back(entry);
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Sends one payload byte, with random idle cycles ahead of it.
   task automatic send_payload_byte(input logic [7:0] data, input logic [7:0] length);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload_byte <= data;
      req_payload_length <= length;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_frame_bytes(data, length);
   endtask

   // Sends count items of random payload; the first carries the given length field, later ones a random one.
   task automatic send_frame(input logic [7:0] length, input int count);
      for (int i = 0; i < count; i++) begin
         send_payload_byte(8'($urandom_range(255)),
                           (i == 0) ? length : 8'($urandom_range(255)));
      end
   endtask

   // Lowers valid and waits until every expected result has arrived.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_wire.size() != 0) @(posedge clock);
   endtask

   // Register write over the configuration port, only while the encoder is idle.
   task automatic write_register(input logic reg_index, input logic [7:0] value);
      wait_results_drained();
      repeat (3) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_index)
         nhfe_pkg::REG_PREFIX: shadow_prefix = value;
         nhfe_pkg::REG_FRAME_TYPE: shadow_frame_type = value;
         default: ;
      endcase
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Default registers with one-byte frames at both payload extremes.
   task automatic test_default_registers();
      send_payload_byte(8'h00, 8'd1);
      send_payload_byte(8'hFF, 8'd1);
      wait_results_drained();
   endtask

   // A zero length field behaves as a one-byte frame.
   task automatic test_zero_length();
      send_payload_byte(8'hA5, 8'd0);
      send_payload_byte(8'h5A, 8'd0);
      wait_results_drained();
   endtask

   // A multi-byte frame with extreme and single-bit payload values.
   task automatic test_payload_extremes();
      send_payload_byte(8'h00, 8'd5);
      send_payload_byte(8'hFF, 8'h00);
      send_payload_byte(8'h80, 8'hFF);
      send_payload_byte(8'h01, 8'h55);
      send_payload_byte(8'h7F, 8'hAA);
      wait_results_drained();
   endtask

   // Both registers at their extremes, then the reverse frame type.
   task automatic test_register_settings();
      write_register(nhfe_pkg::REG_PREFIX, 8'h00);
      write_register(nhfe_pkg::REG_FRAME_TYPE, 8'h00);
      send_frame(8'd2, 2);
      write_register(nhfe_pkg::REG_PREFIX, 8'hFF);
      write_register(nhfe_pkg::REG_FRAME_TYPE, 8'hFF);
      send_frame(8'd1, 1);
      write_register(nhfe_pkg::REG_PREFIX, 8'h01);
      write_register(nhfe_pkg::REG_FRAME_TYPE, 8'hD5);
      send_frame(8'd3, 3);
      write_register(nhfe_pkg::REG_FRAME_TYPE, 8'hD4);
      wait_results_drained();
   endtask

   // The sender holds off mid-frame until the encoder has emptied.
   task automatic test_mid_frame_pause();
      send_frame(8'd4, 2);
      wait_results_drained();
      send_frame(8'd4, 2);
      wait_results_drained();
   endtask

   // The wrapping length opens a frame with LEN and LCS both zero. A full frame
   // would need 255 items, so this runs last and leaves the frame open.
   task automatic test_wrap_length();
      send_frame(8'd255, 4);
      wait_results_drained();
   endtask

   // Random frames, mostly short, under fresh register values.
   task automatic test_random_frames(input int unsigned target);
      int unsigned start_count;
      int unsigned roll;
      int          count;
      start_count = items_sent;
      write_register(nhfe_pkg::REG_PREFIX, 8'($urandom_range(255)));
      write_register(nhfe_pkg::REG_FRAME_TYPE, 8'($urandom_range(255)));
      while (items_sent - start_count < target) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            count = $urandom_range(6, 1);
         end else if (roll < 95) begin
            count = $urandom_range(24, 7);
         end else begin
            count = 0;
         end
         send_frame(8'(count), (count == 0) ? 1 : count);
      end
      wait_results_drained();
   endtask

   // Receiver side: random stall and a check of each accepted result.
   always @(posedge clock) begin : check_wire_results
      wire_result_type want;
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_wire.size() == 0) begin
            report_mismatch("unexpected result", rsp_wire_byte, 0);
         end else begin
            want = expected_wire.pop_front();
            if (rsp_wire_byte !== want.wire_byte)
               report_mismatch("wire_byte", rsp_wire_byte, want.wire_byte);
            if (rsp_last_of_item !== want.last_of_item)
               report_mismatch("last_of_item", rsp_last_of_item, want.last_of_item);
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp_frame_end, want.frame_end);
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no accepted transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload_byte <= 8'h00;
      req_payload_length <= 8'h00;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= 3'd0;
      csr_pwdata <= 32'd0;
      mismatch_count = 0;
      items_sent = 0;
      shadow_prefix = 8'h01;
      shadow_frame_type = 8'hD4;
      shadow_in_frame = 1'b0;
      shadow_bytes_left = 8'd0;
      shadow_checksum = 8'd0;
      set_idling(0, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_zero_length();
      test_payload_extremes();
      test_register_settings();
      set_idling(20, 20);
      test_mid_frame_pause();

      // Random frames under each idling pattern.
      set_idling(0, 0);
      test_random_frames(20);
      set_idling(63, 0);
      test_random_frames(20);
      set_idling(0, 63);
      test_random_frames(20);
      set_idling(20, 20);
      test_random_frames(20);

      test_wrap_length();

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_wire.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
